// File: hw/rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, constants and elaboration-time helpers for the stereo peak
// compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

   localparam int MUL_W      = 32;   // operand width of the shared multiplier
   localparam int PROD_W     = 2 * MUL_W;
   localparam int NORM_W     = 32;   // normalizer word
   localparam int LZ_W       = 5;
   localparam int LOG_W      = 21;   // log2 in Q16, integer part up to 31
   localparam int ROM_W      = 17;
   localparam int COEF_W     = 16;
   localparam int THR_W      = 23;
   localparam int GAIN_W     = 24;   // smoothed gain register, Q2.22
   localparam int AGAIN_W    = 23;   // visible applied gain
   localparam int TOTAL_W    = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0] UNITY_Q22   = 24'd4194304;
   localparam logic [MUL_W-1:0]  SMOOTH_NEW  = 32'd1049;
   localparam logic [MUL_W-1:0]  SMOOTH_OLD  = 32'd1047527;   // 2^20 - 1049
   localparam logic [MUL_W-1:0]  EXP_C1      = 32'd43024;
   localparam logic [MUL_W-1:0]  EXP_C2      = 32'd22512;

   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTACK    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOPE     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAKEUP    = 3'd5;

   localparam logic [COEF_W-1:0] RST_ATTACK    = 16'd65000;
   localparam logic [COEF_W-1:0] RST_RELEASE   = 16'd65500;
   localparam logic [THR_W-1:0]  RST_THRESHOLD = 23'd2097152;
   localparam logic [COEF_W-1:0] RST_SLOPE     = 16'd49152;
   localparam logic [COEF_W-1:0] RST_MAKEUP    = 16'd4096;

   // log2(1 + i/2^ltb) in Q16, truncated, by repeated squaring
   function automatic logic [ROM_W-1:0] log_rom_entry(input int unsigned i,
                                                      input int unsigned ltb);
      logic [63:0]      m;
      logic [ROM_W-1:0] r;
      if (i >= (32'd1 << ltb)) begin
         return 17'd65536;
      end
      m = (64'd1 << 30) + (64'(i) << (30 - ltb));
      r = '0;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         r = r << 1;
         if (m >= (64'd1 << 31)) begin
            r[0] = 1'b1;
            m    = m >> 1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/spc_req_if.sv
// ----------------------------------------------------------------------------
// spc_req_if
// Input channel: one stereo sample pair per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spc_rsp_if.sv
// ----------------------------------------------------------------------------
// spc_rsp_if
// Result channel: processed stereo pair and the applied gain.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic [22:0]                   applied_gain;

   modport source (output valid, output left_out, output right_out,
                   output applied_gain, input ready);
   modport sink   (input valid, input left_out, input right_out,
                   input applied_gain, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spc_csr_if.sv
// ----------------------------------------------------------------------------
// spc_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [31:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spc_mul.sv
// ----------------------------------------------------------------------------
// spc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_mul (
   input  logic                        clock,
   input  logic [spc_pkg::MUL_W-1:0]   mul_a,
   input  logic [spc_pkg::MUL_W-1:0]   mul_b,
   output logic [spc_pkg::PROD_W-1:0]  prod_ff
);
   import spc_pkg::*;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

endmodule

`default_nettype wire

// File: hw/rtl/spc_norm.sv
// ----------------------------------------------------------------------------
// spc_norm
// Iterative leading-one normalizer: binary search, one shift level a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_norm (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [spc_pkg::NORM_W-1:0] x_in,
   output logic                       done_ff,
   output logic [spc_pkg::NORM_W-1:0] n_ff,
   output logic [spc_pkg::LZ_W-1:0]   lz_ff
);
   import spc_pkg::*;

   logic [2:0]      step_ff;
   logic            busy_ff;
   logic [5:0]      amt;
   logic            top_zero;

   always_comb begin
      amt      = 6'd1 << step_ff;
      top_zero = (n_ff >> (6'd32 - amt)) == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            n_ff    <= x_in;
            lz_ff   <= '0;
            step_ff <= 3'd4;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (top_zero) begin
               n_ff  <= n_ff << amt;
               lz_ff <= lz_ff + LZ_W'(amt);
            end
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 3'd1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/stereo_peak_compressor.sv
// ----------------------------------------------------------------------------
// stereo_peak_compressor
// Feedforward peak compressor: envelope follower, log2/exp2 gain law, gain
// smoothing, makeup gain and saturation, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_ch   in   valid/ready   left_sample, right_sample
//  rsp_ch   out  valid/ready   left_out, right_out, applied_gain
//  csr_ch   in   valid/ready   addr, wdata (always ready)
//
//  compressing: the time per item is set by the shared multiplier and
//  the two five-step leading-one searches; the log, slope and exp steps
//  are skipped when the envelope stays at or below threshold, all arithmetic when bypassed
//  one item in flight; the next item is taken while a result waits on rsp_ch
//  reset is synchronous and restores registers, envelope and unity gain
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_peak_compressor #(
   parameter int SAMPLE_BITS    = 24,
   parameter int LOG_TABLE_BITS = 6
) (
   input  logic       clock,
   input  logic       reset,
   spc_req_if.sink    req_ch,
   spc_rsp_if.source  rsp_ch,
   spc_csr_if.sink    csr_ch
);
   import spc_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int LTB   = LOG_TABLE_BITS;
   localparam int REM_W = NORM_W - 1 - LTB;
   localparam int ROM_N = (1 << LTB) + 1;
   localparam logic [PROD_W-1:0] SIGN_Q = PROD_W'(1) << (SB - 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_ENV0, ST_ENV1, ST_ENV2, ST_ENV3, ST_LOGW, ST_LOGM, ST_LOGA,
      ST_OVR, ST_EXPA, ST_EXPB, ST_EXPC, ST_EXPD, ST_EXPE, ST_SM0, ST_SM1,
      ST_SM2, ST_TOT0, ST_TOT1, ST_CHH, ST_CHL, ST_CHQ, ST_OUT
   } state_type;

   // configuration
   logic              enable_ff;
   logic [COEF_W-1:0] attack_ff, release_ff, slope_ff, makeup_ff;
   logic [THR_W-1:0]  thr_ff;

   // working registers
   state_type          state_ff;
   logic [SB-1:0]      mag_l_ff, mag_r_ff, peak_ff, env_ff;
   logic               neg_l_ff, neg_r_ff, ch_ff, which_ff;
   logic [COEF_W-1:0]  c_ff;
   logic [PROD_W-1:0]  acc_ff;
   logic [LZ_W-1:0]    e_ff;
   logic [ROM_W-1:0]   t0_ff, d_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [LOG_W-1:0]   le_ff, lt_ff;
   logic [LZ_W-1:0]    n_ff;
   logic [16:0]        x_ff, inner_ff;
   logic [AGAIN_W-1:0] target_ff;
   logic [GAIN_W-1:0]  g_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [SB-1:0]      ol_ff, or_ff;

   // result register
   logic               rsp_valid_ff;
   logic [SB-1:0]      rsp_l_ff, rsp_r_ff;
   logic [AGAIN_W-1:0] rsp_g_ff;

   // shared units
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic               norm_start, norm_done;
   logic [NORM_W-1:0]  norm_x, norm_n;
   logic [LZ_W-1:0]    norm_lz;

   logic [ROM_W-1:0]   log_rom [ROM_N];

   for (genvar gi = 0; gi < ROM_N; gi++) begin : g_rom
      assign log_rom[gi] = log_rom_entry(gi, LTB);
   end

   spc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_p)
   );

   spc_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .start   (norm_start),
      .x_in    (norm_x),
      .done_ff (norm_done),
      .n_ff    (norm_n),
      .lz_ff   (norm_lz)
   );

   // combinational helpers
   logic               req_acc, rsp_free;
   logic [SB-1:0]      in_mag_l, in_mag_r, in_peak;
   logic [THR_W-1:0]   thr_eff;
   logic               env_gt;
   logic [LTB-1:0]     rom_idx;
   logic [LOG_W-1:0]   log_val, over;
   logic [17:0]        exp_p;
   logic [SB-1:0]      mag_sel;
   logic               neg_sel;
   logic [PROD_W-1:0]  q_val;
   logic [SB-1:0]      sat_val;

   always_comb begin
      req_acc  = req_ch.valid && req_ch.ready;
      rsp_free = !rsp_valid_ff || rsp_ch.ready;
      in_mag_l = req_ch.left_sample[SB-1]  ? SB'(0 - req_ch.left_sample)
                                          : req_ch.left_sample;
      in_mag_r = req_ch.right_sample[SB-1] ? SB'(0 - req_ch.right_sample)
                                          : req_ch.right_sample;
      in_peak  = (in_mag_l > in_mag_r) ? in_mag_l : in_mag_r;
      thr_eff  = (thr_ff == '0) ? THR_W'(1) : thr_ff;
      env_gt   = NORM_W'(env_ff) > NORM_W'(thr_eff);
      rom_idx  = norm_n[NORM_W-2 -: LTB];
      log_val  = LOG_W'({e_ff, 16'd0}) + LOG_W'(t0_ff) + LOG_W'(mul_p >> REM_W);
      over     = (le_ff > lt_ff) ? le_ff - lt_ff : '0;
      exp_p    = 18'd65536 + 18'(mul_p >> 16);
      mag_sel  = ch_ff ? mag_r_ff : mag_l_ff;
      neg_sel  = ch_ff ? neg_r_ff : neg_l_ff;
      q_val    = (acc_ff + ((mul_p + (PROD_W'(1) << 33)) >> 16)) >> 18;
      if (neg_sel) begin
         sat_val = SB'(0 - ((q_val > SIGN_Q) ? SIGN_Q : q_val));
      end else begin
         sat_val = SB'((q_val > SIGN_Q - 1) ? SIGN_Q - 1 : q_val);
      end
      norm_start = (state_ff == ST_ENV3 && env_gt) || (state_ff == ST_LOGA && !which_ff);
      norm_x     = (state_ff == ST_ENV3) ? NORM_W'(env_ff) : NORM_W'(thr_eff);
   end

   // operand selection for the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_ENV0: begin mul_a = MUL_W'(c_ff);                  mul_b = MUL_W'(env_ff);  end
         ST_ENV1: begin mul_a = MUL_W'(17'd65536 - 17'(c_ff)); mul_b = MUL_W'(peak_ff); end
         ST_LOGM: begin mul_a = MUL_W'(d_ff);                  mul_b = MUL_W'(rem_ff);  end
         ST_OVR:  begin mul_a = MUL_W'(over);                  mul_b = MUL_W'(slope_ff); end
         ST_EXPB: begin mul_a = EXP_C2;                        mul_b = MUL_W'(x_ff);    end
         ST_EXPD: begin mul_a = MUL_W'(x_ff);                  mul_b = MUL_W'(inner_ff); end
         ST_SM0:  begin mul_a = SMOOTH_OLD;                    mul_b = MUL_W'(g_ff);    end
         ST_SM1:  begin mul_a = SMOOTH_NEW;                    mul_b = MUL_W'(target_ff); end
         ST_TOT0: begin mul_a = MUL_W'(g_ff);                  mul_b = MUL_W'(makeup_ff); end
         ST_CHH:  begin mul_a = MUL_W'(mag_sel);  mul_b = MUL_W'(total_ff[TOTAL_W-1:16]); end
         ST_CHL:  begin mul_a = MUL_W'(mag_sel);  mul_b = MUL_W'(total_ff[15:0]);         end
         default: begin mul_a = '0;                            mul_b = '0;              end
      endcase
   end

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         attack_ff  <= RST_ATTACK;
         release_ff <= RST_RELEASE;
         thr_ff     <= RST_THRESHOLD;
         slope_ff   <= RST_SLOPE;
         makeup_ff  <= RST_MAKEUP;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            CSR_ENABLE:    enable_ff  <= csr_ch.wdata[0];
            CSR_ATTACK:    attack_ff  <= csr_ch.wdata[COEF_W-1:0];
            CSR_RELEASE:   release_ff <= csr_ch.wdata[COEF_W-1:0];
            CSR_THRESHOLD: thr_ff     <= csr_ch.wdata[THR_W-1:0];
            CSR_SLOPE:     slope_ff   <= csr_ch.wdata[COEF_W-1:0];
            CSR_MAKEUP:    makeup_ff  <= csr_ch.wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= '0;
         g_ff         <= UNITY_Q22;
         rsp_valid_ff <= 1'b0;
         ch_ff        <= 1'b0;
         which_ff     <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  mag_l_ff <= in_mag_l;
                  mag_r_ff <= in_mag_r;
                  neg_l_ff <= req_ch.left_sample[SB-1];
                  neg_r_ff <= req_ch.right_sample[SB-1];
                  peak_ff  <= in_peak;
                  c_ff     <= (in_peak > env_ff) ? attack_ff : release_ff;
                  ol_ff    <= req_ch.left_sample;
                  or_ff    <= req_ch.right_sample;
                  ch_ff    <= 1'b0;
                  state_ff <= enable_ff ? ST_ENV0 : ST_OUT;
               end
            end
            ST_ENV0: state_ff <= ST_ENV1;
            ST_ENV1: begin
               acc_ff   <= mul_p;
               state_ff <= ST_ENV2;
            end
            ST_ENV2: begin
               env_ff   <= SB'((acc_ff + mul_p + PROD_W'(32768)) >> 16);
               state_ff <= ST_ENV3;
            end
            ST_ENV3: begin
               if (env_gt) begin
                  which_ff <= 1'b0;
                  state_ff <= ST_LOGW;
               end else begin
                  target_ff <= AGAIN_W'(UNITY_Q22);
                  state_ff  <= ST_SM0;
               end
            end
            ST_LOGW: begin
               if (norm_done) begin
                  e_ff     <= LZ_W'(5'd31 - norm_lz);
                  t0_ff    <= log_rom[{1'b0, rom_idx}];
                  d_ff     <= log_rom[(LTB+1)'(rom_idx) + 1'b1] - log_rom[{1'b0, rom_idx}];
                  rem_ff   <= norm_n[REM_W-1:0];
                  state_ff <= ST_LOGM;
               end
            end
            ST_LOGM: state_ff <= ST_LOGA;
            ST_LOGA: begin
               if (!which_ff) begin
                  le_ff    <= log_val;
                  which_ff <= 1'b1;
                  state_ff <= ST_LOGW;
               end else begin
                  lt_ff    <= log_val;
                  state_ff <= ST_OVR;
               end
            end
            ST_OVR: state_ff <= ST_EXPA;
            ST_EXPA: begin
               // reduction of the Q32 product: integer part shifts, Q16 fraction feeds the polynomial
               n_ff     <= mul_p[36:32];
               x_ff     <= 17'(17'd65536 - 17'(mul_p[31:16]));
               state_ff <= ST_EXPB;
            end
            ST_EXPB: state_ff <= ST_EXPC;
            ST_EXPC: begin
               inner_ff <= 17'(EXP_C1) + 17'(mul_p[31:16]);
               state_ff <= ST_EXPD;
            end
            ST_EXPD: state_ff <= ST_EXPE;
            ST_EXPE: begin
               target_ff <= AGAIN_W'({exp_p, 5'd0}) >> n_ff;
               state_ff  <= ST_SM0;
            end
            ST_SM0: state_ff <= ST_SM1;
            ST_SM1: begin
               acc_ff   <= mul_p;
               state_ff <= ST_SM2;
            end
            ST_SM2: begin
               g_ff     <= GAIN_W'((acc_ff + mul_p + (PROD_W'(1) << 19)) >> 20);
               state_ff <= ST_TOT0;
            end
            ST_TOT0: state_ff <= ST_TOT1;
            ST_TOT1: begin
               total_ff <= mul_p[TOTAL_W-1:0];
               state_ff <= ST_CHH;
            end
            ST_CHH: state_ff <= ST_CHL;
            ST_CHL: begin
               acc_ff   <= mul_p;
               state_ff <= ST_CHQ;
            end
            ST_CHQ: begin
               if (ch_ff) begin
                  or_ff    <= sat_val;
                  state_ff <= ST_OUT;
               end else begin
                  ol_ff    <= sat_val;
                  ch_ff    <= 1'b1;
                  state_ff <= ST_CHH;
               end
            end
            ST_OUT: begin
               if (rsp_free) begin
                  rsp_l_ff     <= ol_ff;
                  rsp_r_ff     <= or_ff;
                  rsp_g_ff     <= g_ff[AGAIN_W-1:0];
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.left_out     = rsp_l_ff;
   assign rsp_ch.right_out    = rsp_r_ff;
   assign rsp_ch.applied_gain = rsp_g_ff;

   // bypassed items skip all arithmetic
   a_bypass: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !enable_ff) |=> (state_ff == ST_OUT))
      else $error("bypass item did not go straight to output");

   // envelope is a weighted mean of magnitudes, never above full scale
   a_env_range: assert property (@(posedge clock) disable iff (reset)
      (PROD_W'(env_ff) <= SIGN_Q))
      else $error("envelope above full scale");

   // a fresh result carries the current smoothed gain
   a_gain_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_ch.applied_gain == g_ff[AGAIN_W-1:0]))
      else $error("applied gain does not match smoothed gain");

   // log stage only proceeds after the normalizer has finished
   a_norm_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOGM) |-> $past(norm_done))
      else $error("log interpolation started before normalization");

endmodule

`default_nettype wire
